// File: sv/sphb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphb_pkg
// Shared constants for the spatial-hash bucket insert block.
// ----------------------------------------------------------------------------
package sphb_pkg;

	localparam int unsigned TABLE_ENTRIES = 65536;
	localparam int unsigned TABLE_AW      = $clog2(TABLE_ENTRIES);
	localparam int unsigned MAX_PARTICLES = 65536;

	localparam int unsigned ID_W    = 16;
	localparam int unsigned POS_W   = 32;
	localparam int unsigned CS_W    = 31;
	localparam int unsigned LINK_W  = 17;
	localparam int unsigned BKT_W   = 16;
	localparam int unsigned CNT_W   = $clog2(POS_W);

	localparam logic [POS_W-1:0]  PRIME_X    = 32'd73856093;
	localparam logic [POS_W-1:0]  PRIME_Y    = 32'd19349663;
	localparam logic [POS_W-1:0]  PRIME_Z    = 32'd83492791;
	localparam logic [LINK_W-1:0] EMPTY_HEAD = 17'h1FFFF;
	localparam logic [CS_W-1:0]   CELL_RESET = 31'd65536;

	localparam logic [POS_W-1:0]  CELL_MAX   = 32'h7FFF_FFFF;
	localparam logic [POS_W-1:0]  CELL_MIN   = 32'h8000_0000;

	// Axis codes
	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	// Input selector
	localparam logic ACT_CLEAR  = 1'b0;
	localparam logic ACT_INSERT = 1'b1;

	typedef enum logic [8:0] {
		S_INIT  = 9'b000000001,
		S_IDLE  = 9'b000000010,
		S_LOAD  = 9'b000000100,
		S_DIV   = 9'b000001000,
		S_MUL   = 9'b000010000,
		S_READ  = 9'b000100000,
		S_EMIT  = 9'b001000000,
		S_CLEAR = 9'b010000000,
		S_DONE  = 9'b100000000
	} state_t;

endpackage

// File: sv/spatial_hash_bucket_insert.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spatial_hash_bucket_insert
// Linked-cell insert into a hashed grid with a 64Ki-entry head table.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream (s_*) takes one command per transfer; s_tuser is the action,
//   0 clears every bucket head, 1 inserts a particle. An insert divides each
//   Q16.16 coordinate by cell_size (truncating toward zero), hashes the three
//   cells into a bucket, sends the bucket's old head out as the particle's
//   next link and makes the particle the new head.
//   Master stream (m_*) returns one result per command: bucket index and the
//   next link (-1 for an empty bucket, and for a clear).
//   cfg_we/cfg_data write cell_size; write it only while the block is idle.
// Operation:
//   One restoring divider shared by the three axes retires a quotient bit per
//   cycle; each axis runs a load step, the divide steps and a hash multiply.
//   After a table read, an insert writes its table entry back as it loads its
//   result, and only then takes the next command. A clear sweeps the table
//   one entry a cycle, then offers its result.
// Reset: after arst_n the same sweep runs with s_tready low;
//   cell_size returns to 1.0 (65536).
// Stall: a finished result waits in the output register; while m_tready is
//   low the next command is still taken and worked on, then held before its
//   table write until the output register frees.
// ----------------------------------------------------------------------------
module spatial_hash_bucket_insert (
	input  logic          clk,
	input  logic          arst_n,
	// configuration
	input  logic          cfg_we,
	input  logic [30:0]   cfg_data,   // cell_size, unsigned Q15.16
	// command stream
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [111:0]  s_tdata,    // particle_id[15:0], pos_x[47:16],
	                                  // pos_y[79:48], pos_z[111:80]
	input  logic          s_tuser,    // action: 0 clear, 1 insert
	// result stream
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [39:0]   m_tdata     // bucket_index[15:0], next_link[32:16],
	                                  // zero pad[39:33]
);
	import sphb_pkg::*;

	state_t state_q;

	logic [CS_W-1:0]     cell_size_q;

	// captured command
	logic [ID_W-1:0]     id_q;
	logic [POS_W-1:0]    pos_q [3];
	logic [1:0]          axis_q;

	// shared divider
	logic [POS_W-1:0]    quo_q;     // dividend shifting out, quotient shifting in
	logic [CS_W-1:0]     rem_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                neg_q;
	logic                mag_zero_q;

	logic [POS_W-1:0]    hash_q;
	logic                clr_q;     // current sweep answers a clear command

	// table sweep and memory
	logic [TABLE_AW-1:0] clr_addr_q;
	logic [LINK_W-1:0]   heads [TABLE_ENTRIES];
	logic [LINK_W-1:0]   rd_data_q;
	logic                mem_we;
	logic [TABLE_AW-1:0] mem_waddr;
	logic [LINK_W-1:0]   mem_wdata;
	logic [TABLE_AW-1:0] mem_raddr;

	// output register
	logic                out_valid_q;
	logic [BKT_W-1:0]    out_bucket_q;
	logic [LINK_W-1:0]   out_link_q;

	logic                slot_free;
	logic                in_fire;
	logic                id_ok;

	logic [POS_W-1:0]    pos_sel;
	logic [POS_W-1:0]    mag;
	logic [POS_W-1:0]    shifted;
	logic [POS_W:0]      diff;
	logic                take;
	logic [POS_W-1:0]    cell_coord;
	logic [POS_W-1:0]    prime;
	logic [POS_W-1:0]    prod;

	localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(POS_W - 1);
	localparam logic [TABLE_AW-1:0] ADDR_LAST = {TABLE_AW{1'b1}};

	assign s_tready  = (state_q == S_IDLE);
	assign in_fire   = s_tvalid && s_tready;
	assign slot_free = !out_valid_q || m_tready;
	assign id_ok     = (32'(id_q) < MAX_PARTICLES);

	assign m_tvalid  = out_valid_q;
	assign m_tdata   = {7'd0, out_link_q, out_bucket_q};

	// Operand of the axis in work, and its magnitude
	assign pos_sel = pos_q[axis_q];
	assign mag     = pos_sel[POS_W-1] ? (~pos_sel + 32'd1) : pos_sel;

	// One restoring divide step: shift in the next dividend bit, trial subtract
	assign shifted = {rem_q, quo_q[POS_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, cell_size_q};
	assign take    = !diff[POS_W];

	// Signed cell from the finished quotient; zero cell size saturates
	always_comb begin
		if (cell_size_q == '0) begin
			if (mag_zero_q) begin
				cell_coord = '0;
			end else if (neg_q) begin
				cell_coord = CELL_MIN;
			end else begin
				cell_coord = CELL_MAX;
			end
		end else begin
			cell_coord = neg_q ? (~quo_q + 32'd1) : quo_q;
		end
	end

	always_comb begin
		case (axis_q)
			AXIS_X:  prime = PRIME_X;
			AXIS_Y:  prime = PRIME_Y;
			AXIS_Z:  prime = PRIME_Z;
			default: prime = PRIME_X;
		endcase
	end

	// Shared multiplier, wrapping to 32 bits
	assign prod = cell_coord * prime;

	// Table port control
	assign mem_raddr = hash_q[TABLE_AW-1:0];

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = clr_addr_q;
		mem_wdata = EMPTY_HEAD;
		case (state_q)
			S_INIT, S_CLEAR: begin
				mem_we = 1'b1;
			end
			S_EMIT: begin
				if (slot_free && id_ok) begin
					mem_we    = 1'b1;
					mem_waddr = hash_q[TABLE_AW-1:0];
					mem_wdata = {1'b0, id_q};
				end
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// Head table: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			heads[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= heads[mem_raddr];
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_size_q <= CELL_RESET;
		end else if (cfg_we) begin
			cell_size_q <= cfg_data;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_INIT;
			clr_addr_q <= '0;
			axis_q     <= AXIS_X;
			cnt_q      <= '0;
			clr_q      <= 1'b0;
		end else begin
			case (state_q)
				S_INIT, S_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == ADDR_LAST) begin
						state_q <= (state_q == S_CLEAR) ? S_DONE : S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_fire) begin
						axis_q     <= AXIS_X;
						clr_addr_q <= '0;
						clr_q      <= (s_tuser == ACT_CLEAR);
						state_q    <= (s_tuser == ACT_INSERT) ? S_LOAD : S_CLEAR;
					end
				end
				S_LOAD: begin
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == DIV_LAST) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					if (axis_q == AXIS_Z) begin
						state_q <= S_READ;
					end else begin
						axis_q  <= axis_q + 2'd1;
						state_q <= S_LOAD;
					end
				end
				S_READ: begin
					// read data lands in rd_data_q at this edge
					state_q <= S_EMIT;
				end
				S_EMIT, S_DONE: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers: capture, divide, hash
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					id_q     <= s_tdata[15:0];
					pos_q[0] <= s_tdata[47:16];
					pos_q[1] <= s_tdata[79:48];
					pos_q[2] <= s_tdata[111:80];
					hash_q   <= '0;
				end
			end
			S_LOAD: begin
				quo_q      <= mag;
				rem_q      <= '0;
				neg_q      <= pos_sel[POS_W-1];
				mag_zero_q <= (pos_sel == '0);
			end
			S_DIV: begin
				rem_q <= take ? diff[CS_W-1:0] : shifted[CS_W-1:0];
				quo_q <= {quo_q[POS_W-2:0], take};
			end
			S_MUL: begin
				hash_q <= hash_q ^ prod;
			end
			default: begin
				hash_q <= hash_q;
			end
		endcase
	end

	// Output register: load a result when the slot frees, drop it on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_EMIT || state_q == S_DONE) && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free) begin
			if (state_q == S_DONE) begin
				out_bucket_q <= '0;
				out_link_q   <= EMPTY_HEAD;
			end else if (state_q == S_EMIT) begin
				out_bucket_q <= BKT_W'(hash_q[TABLE_AW-1:0]);
				out_link_q   <= id_ok ? rd_data_q : EMPTY_HEAD;
			end
		end
	end

`ifndef ASSERT_OFF
	// The table is never written while the block waits for a command
	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !mem_we)
		else $error("head table written while idle");

	// A command transfer closes the input until its result is produced
	a_busy_after_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !s_tready)
		else $error("input still ready after a command transfer");

	// The divider runs exactly one quotient bit per cycle, then hashes
	a_div_to_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && cnt_q == DIV_LAST) |=> (state_q == S_MUL))
		else $error("divider did not hand over to the hash step");

	// A clear result only follows a clear sweep
	a_done_after_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) |-> clr_q)
		else $error("clear result without a clear command");
`endif

endmodule
